>>> hw/rtl/aws_pkg.sv
package aws_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int BANK_AW    = XW + YW - 2;
   localparam int BANK_DEPTH = 2 ** BANK_AW;
   localparam int DIM_W      = 10;
   localparam int NW         = (XW + 1 > DIM_W) ? XW + 1 : DIM_W;
   localparam int COEF_W     = 32;
   localparam int POS_W      = 16;
   localparam int CH_W       = 16;
   localparam int PROD_W     = POS_W + 1 + COEF_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int FRAC_W     = 8;
   localparam int Q_W        = SUM_W - FRAC_W;
   localparam int ONE_Q8     = 256;
   localparam int WGT_W      = 16;
   localparam int MUL_W      = CH_W + WGT_W;
   localparam int ACC_W      = MUL_W + 2;
   localparam int ROUND_BIAS = 16384;
   localparam int ROUND_SH   = 15;
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = FIFO_AW + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT,
      CSR_COEF_COL_X,
      CSR_COEF_COL_Y,
      CSR_COEF_ROW_X,
      CSR_COEF_ROW_Y,
      CSR_OFFSET_X,
      CSR_OFFSET_Y
   } csr_idx_type;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [DIM_W-1:0]         src_width;
      logic [DIM_W-1:0]         src_height;
      logic signed [COEF_W-1:0] coef_col_x;
      logic signed [COEF_W-1:0] coef_col_y;
      logic signed [COEF_W-1:0] coef_row_x;
      logic signed [COEF_W-1:0] coef_row_y;
      logic signed [COEF_W-1:0] offset_x;
      logic signed [COEF_W-1:0] offset_y;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [1:0]         bank;
      logic [BANK_AW-1:0] addr;
      pixel_type          pixel;
   } mem_wr_type;

   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [XW-1:0]     ix;
      logic [YW-1:0]     iy;
      logic [FRAC_W-1:0] fx;
      logic [FRAC_W-1:0] fy;
      logic              step_x;
      logic              step_y;
   } samp_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            hit;
   } rsp_type;

endpackage

>>> hw/rtl/aws_req_if.sv
interface aws_req_if import aws_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [CH_W-1:0]  red_in;
   logic [CH_W-1:0]  green_in;
   logic [CH_W-1:0]  blue_in;

   modport source (output valid, kind, pos_x, pos_y, red_in, green_in, blue_in,
                   input ready);
   modport sink (input valid, kind, pos_x, pos_y, red_in, green_in, blue_in,
                 output ready);
endinterface

>>> hw/rtl/aws_rsp_if.sv
interface aws_rsp_if import aws_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red_out;
   logic [CH_W-1:0] green_out;
   logic [CH_W-1:0] blue_out;
   logic            inside_res;

   modport source (output valid, red_out, green_out, blue_out, inside_res,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, inside_res,
                 output ready);
endinterface

>>> hw/rtl/aws_map.sv
module aws_map import aws_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  kind_type         in_kind,
   input  logic [POS_W-1:0] in_pos_x,
   input  logic [POS_W-1:0] in_pos_y,
   input  pixel_type        in_pixel,
   input  cfg_type          cfg,
   output mem_wr_type       wr_out,
   output samp_type         samp_out
);

   typedef struct packed {
      logic              ok;
      logic [NW-1:0]     ip;
      logic [FRAC_W-1:0] frac;
      logic              step;
   } axis_type;

   function automatic axis_type resolve(input logic signed [Q_W-1:0] q,
                                        input logic [NW-1:0] n);
      axis_type a;
      logic signed [Q_W-FRAC_W-1:0] ip;
      logic [NW:0] nxt;
      ip = q[Q_W-1:FRAC_W];
      a = '0;
      nxt = '0;
      if (n == '0 || ip < -1) begin
         a.ok = 1'b0;
      end else if (q[Q_W-1]) begin
         // just left of / above the image: clamp to the first pixel
         a.ok = 1'b1;
         a.step = NW'(1) < n;
      end else if (ip >= $signed({1'b0, n})) begin
         a.ok = 1'b0;
      end else begin
         a.ok = 1'b1;
         a.ip = ip[NW-1:0];
         a.frac = q[FRAC_W-1:0];
         nxt = {1'b0, ip[NW-1:0]} + (NW+1)'(1);
         a.step = nxt < {1'b0, n};
      end
      return a;
   endfunction

   // stage 1: input capture
   logic v1_ff, k1_ff;
   logic [POS_W-1:0] px1_ff, py1_ff;
   pixel_type pix1_ff;

   // stage 2: products
   logic v2_ff, k2_ff, ld2_ff;
   logic [1:0] bank2_ff;
   logic [BANK_AW-1:0] addr2_ff;
   pixel_type pix2_ff;
   logic signed [PROD_W-1:0] pcx2_ff, pcy2_ff, prx2_ff, pry2_ff;
   logic signed [PROD_W-1:0] pcx2_in, pcy2_in, prx2_in, pry2_in;
   logic ld2_in;

   // stage 3: sums
   logic v3_ff, k3_ff, ld3_ff;
   logic [1:0] bank3_ff;
   logic [BANK_AW-1:0] addr3_ff;
   pixel_type pix3_ff;
   logic signed [SUM_W-1:0] sx3_ff, sy3_ff, sx3_in, sy3_in;

   // stage 4: truncate to q8
   logic v4_ff, k4_ff, ld4_ff;
   logic [1:0] bank4_ff;
   logic [BANK_AW-1:0] addr4_ff;
   pixel_type pix4_ff;
   logic signed [Q_W-1:0] qx4_ff, qy4_ff, qx4_in, qy4_in;

   // stage 5: axis resolve
   mem_wr_type wr_ff, wr_in;
   samp_type samp_ff, samp_in;
   axis_type ax, ay;
   logic [NW-1:0] nx, ny;

   always_comb begin
      pcx2_in = $signed({1'b0, px1_ff}) * cfg.coef_col_x;
      pcy2_in = $signed({1'b0, px1_ff}) * cfg.coef_col_y;
      prx2_in = $signed({1'b0, py1_ff}) * cfg.coef_row_x;
      pry2_in = $signed({1'b0, py1_ff}) * cfg.coef_row_y;
      ld2_in = (px1_ff < POS_W'(MAX_WIDTH)) && (py1_ff < POS_W'(MAX_HEIGHT));
   end

   always_comb begin
      sx3_in = SUM_W'(pcx2_ff) + SUM_W'(prx2_ff) + SUM_W'(cfg.offset_x);
      sy3_in = SUM_W'(pcy2_ff) + SUM_W'(pry2_ff) + SUM_W'(cfg.offset_y);
   end

   // truncation toward zero: floor, plus one for a negative value with a remainder
   always_comb begin
      qx4_in = Q_W'(sx3_ff >>> FRAC_W)
             + Q_W'(sx3_ff[SUM_W-1] && (sx3_ff[FRAC_W-1:0] != '0));
      qy4_in = Q_W'(sy3_ff >>> FRAC_W)
             + Q_W'(sy3_ff[SUM_W-1] && (sy3_ff[FRAC_W-1:0] != '0));
   end

   always_comb begin
      nx = (NW'(cfg.src_width) > NW'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : NW'(cfg.src_width);
      ny = (NW'(cfg.src_height) > NW'(MAX_HEIGHT)) ? NW'(MAX_HEIGHT) : NW'(cfg.src_height);
      ax = resolve(qx4_ff, nx);
      ay = resolve(qy4_ff, ny);
      samp_in.valid  = v4_ff && (k4_ff == KIND_SAMPLE);
      samp_in.hit    = ax.ok && ay.ok;
      samp_in.ix     = ax.ip[XW-1:0];
      samp_in.iy     = ay.ip[YW-1:0];
      samp_in.fx     = ax.frac;
      samp_in.fy     = ay.frac;
      samp_in.step_x = ax.step;
      samp_in.step_y = ay.step;
      wr_in.en    = v4_ff && (k4_ff == KIND_LOAD) && ld4_ff;
      wr_in.bank  = bank4_ff;
      wr_in.addr  = addr4_ff;
      wr_in.pixel = pix4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         samp_ff.valid <= 1'b0;
         wr_ff.en <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         samp_ff.valid <= samp_in.valid;
         wr_ff.en <= wr_in.en;
      end
      k1_ff <= in_kind;
      px1_ff <= in_pos_x;
      py1_ff <= in_pos_y;
      pix1_ff <= in_pixel;

      k2_ff <= k1_ff;
      ld2_ff <= ld2_in;
      bank2_ff <= {py1_ff[0], px1_ff[0]};
      addr2_ff <= {py1_ff[YW-1:1], px1_ff[XW-1:1]};
      pix2_ff <= pix1_ff;
      pcx2_ff <= pcx2_in;
      pcy2_ff <= pcy2_in;
      prx2_ff <= prx2_in;
      pry2_ff <= pry2_in;

      k3_ff <= k2_ff;
      ld3_ff <= ld2_ff;
      bank3_ff <= bank2_ff;
      addr3_ff <= addr2_ff;
      pix3_ff <= pix2_ff;
      sx3_ff <= sx3_in;
      sy3_ff <= sy3_in;

      k4_ff <= k3_ff;
      ld4_ff <= ld3_ff;
      bank4_ff <= bank3_ff;
      addr4_ff <= addr3_ff;
      pix4_ff <= pix3_ff;
      qx4_ff <= qx4_in;
      qy4_ff <= qy4_in;

      samp_ff.hit <= samp_in.hit;
      samp_ff.ix <= samp_in.ix;
      samp_ff.iy <= samp_in.iy;
      samp_ff.fx <= samp_in.fx;
      samp_ff.fy <= samp_in.fy;
      samp_ff.step_x <= samp_in.step_x;
      samp_ff.step_y <= samp_in.step_y;
      wr_ff.bank <= wr_in.bank;
      wr_ff.addr <= wr_in.addr;
      wr_ff.pixel <= wr_in.pixel;
   end

   assign wr_out = wr_ff;
   assign samp_out = samp_ff;

endmodule

>>> hw/rtl/aws_store.sv
module aws_store import aws_pkg::*; (
   input  logic       clock,
   input  mem_wr_type wr,
   input  samp_type   samp,
   output pixel_type  rd_data [4]
);

   // bank index is {row parity, column parity}
   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam int BX = b % 2;
      localparam int BY = b / 2;
      pixel_type mem [BANK_DEPTH];
      pixel_type rd_ff;
      logic [XW:0] xs;
      logic [YW:0] ys;
      logic [BANK_AW-1:0] ra;

      // pick the column / row of this parity within the 2x2 window
      always_comb begin
         xs = {1'b0, samp.ix} + (XW+1)'(samp.ix[0] != 1'(BX));
         ys = {1'b0, samp.iy} + (YW+1)'(samp.iy[0] != 1'(BY));
         ra = {ys[YW-1:1], xs[XW-1:1]};
      end

      always_ff @(posedge clock) begin
         if (wr.en && (wr.bank == 2'(b))) begin
            mem[wr.addr] <= wr.pixel;
         end
         rd_ff <= mem[ra];
      end

      assign rd_data[b] = rd_ff;
   end

endmodule

>>> hw/rtl/aws_blend.sv
module aws_blend import aws_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  samp_type  samp,
   input  pixel_type rd_data [4],
   output logic      push,
   output rsp_type   push_data
);

   localparam int WP_W = 2 * (FRAC_W + 1);

   // stage 6: weights, in parallel with the memory read
   logic v6_ff, in6_ff;
   logic [1:0] sel6_ff [4];
   logic [1:0] sel6_in [4];
   logic [WGT_W-1:0] w6_ff [4];
   logic [WGT_W-1:0] w6_in [4];
   logic [FRAC_W:0] dx, dy, ndx, ndy;
   logic [WP_W-1:0] wp [4];

   // stage 7: products
   logic v7_ff, in7_ff;
   logic [MUL_W-1:0] prod7_ff [3][4];
   logic [MUL_W-1:0] prod7_in [3][4];
   pixel_type pk;

   // stage 8: sum and round
   logic v8_ff;
   rsp_type res8_ff, res8_in;
   logic [ACC_W-1:0] acc [3];

   always_comb begin
      dx = {1'b0, samp.fx};
      dy = {1'b0, samp.fy};
      ndx = (FRAC_W+1)'(ONE_Q8) - dx;
      ndy = (FRAC_W+1)'(ONE_Q8) - dy;
      wp[0] = ndx * ndy;
      wp[1] = dx * ndy;
      wp[2] = ndx * dy;
      wp[3] = dx * dy;
      for (int k = 0; k < 4; k++) begin
         w6_in[k] = wp[k][WGT_W:1];
      end
      sel6_in[0] = {samp.iy[0], samp.ix[0]};
      sel6_in[1] = {samp.iy[0], samp.ix[0] ^ samp.step_x};
      sel6_in[2] = {samp.iy[0] ^ samp.step_y, samp.ix[0]};
      sel6_in[3] = {samp.iy[0] ^ samp.step_y, samp.ix[0] ^ samp.step_x};
   end

   always_comb begin
      pk = '0;
      for (int k = 0; k < 4; k++) begin
         pk = rd_data[sel6_ff[k]];
         prod7_in[0][k] = pk.red * w6_ff[k];
         prod7_in[1][k] = pk.green * w6_ff[k];
         prod7_in[2][k] = pk.blue * w6_ff[k];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = ACC_W'(prod7_ff[c][0]) + ACC_W'(prod7_ff[c][1])
                + ACC_W'(prod7_ff[c][2]) + ACC_W'(prod7_ff[c][3])
                + ACC_W'(ROUND_BIAS);
      end
      res8_in.hit   = in7_ff;
      res8_in.red   = in7_ff ? acc[0][ROUND_SH +: CH_W] : '0;
      res8_in.green = in7_ff ? acc[1][ROUND_SH +: CH_W] : '0;
      res8_in.blue  = in7_ff ? acc[2][ROUND_SH +: CH_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v6_ff <= samp.valid;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
      in6_ff <= samp.hit;
      sel6_ff <= sel6_in;
      w6_ff <= w6_in;
      in7_ff <= in6_ff;
      prod7_ff <= prod7_in;
      res8_ff <= res8_in;
   end

   assign push = v8_ff;
   assign push_data = res8_ff;

endmodule

>>> hw/rtl/aws_fifo.sv
module aws_fifo import aws_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    valid,
   input  logic    ready,
   output rsp_type head
);

   rsp_type mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic pop;

   always_comb begin
      pop = valid && ready;
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign valid = cnt_ff != '0;
   assign head = mem[rd_ptr_ff];

endmodule

>>> hw/rtl/affine_warp_bilinear_sampler_unit.sv
// a sample transaction's result passes the map, bank read, blend and result queue registers
// throughput: one transaction (load or sample) per cycle, each of the four pixel
// banks has one read and one write port; input stalls only while 16 samples are
// in flight or queued, loads write the banks from the map's output register, no result
// reset: synchronous, clears pipeline valids, result queue and credits, and
// restores register defaults; pixel banks are not cleared
module affine_warp_bilinear_sampler_unit import aws_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   aws_req_if.sink               req_chan,
   aws_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff;
   logic [CNT_W-1:0] credit_ff, credit_in;
   logic req_acc, rsp_pop, samp_acc;
   pixel_type req_pixel;
   mem_wr_type wr;
   samp_type samp;
   pixel_type rd_data [4];
   logic push;
   rsp_type push_data, head;
   logic fifo_valid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= DIM_W'(1);
         cfg_ff.src_height <= DIM_W'(1);
         cfg_ff.coef_col_x <= COEF_W'(65536);
         cfg_ff.coef_col_y <= '0;
         cfg_ff.coef_row_x <= '0;
         cfg_ff.coef_row_y <= COEF_W'(65536);
         cfg_ff.offset_x   <= '0;
         cfg_ff.offset_y   <= '0;
      end else if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_SRC_WIDTH:  cfg_ff.src_width  <= csr_data[DIM_W-1:0];
            CSR_SRC_HEIGHT: cfg_ff.src_height <= csr_data[DIM_W-1:0];
            CSR_COEF_COL_X: cfg_ff.coef_col_x <= csr_data;
            CSR_COEF_COL_Y: cfg_ff.coef_col_y <= csr_data;
            CSR_COEF_ROW_X: cfg_ff.coef_row_x <= csr_data;
            CSR_COEF_ROW_Y: cfg_ff.coef_row_y <= csr_data;
            CSR_OFFSET_X:   cfg_ff.offset_x   <= csr_data;
            CSR_OFFSET_Y:   cfg_ff.offset_y   <= csr_data;
            default: ;
         endcase
      end
   end

   // credit counter: samples in flight plus results queued never exceed the
   // queue depth, so the pipeline itself never stalls
   always_comb begin
      req_acc   = req_chan.valid && req_chan.ready;
      samp_acc  = req_acc && (kind_type'(req_chan.kind) == KIND_SAMPLE);
      rsp_pop   = rsp_chan.valid && rsp_chan.ready;
      credit_in = credit_ff + CNT_W'(samp_acc) - CNT_W'(rsp_pop);
      req_pixel.red   = req_chan.red_in;
      req_pixel.green = req_chan.green_in;
      req_pixel.blue  = req_chan.blue_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   assign req_chan.ready = credit_ff < CNT_W'(FIFO_DEPTH);

   // coordinate mapping: products, sums, truncation, edge handling
   aws_map u_map (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_acc),
      .in_kind  (kind_type'(req_chan.kind)),
      .in_pos_x (req_chan.pos_x),
      .in_pos_y (req_chan.pos_y),
      .in_pixel (req_pixel),
      .cfg      (cfg_ff),
      .wr_out   (wr),
      .samp_out (samp)
   );

   // four parity banks: the 2x2 window always hits each bank once, and a
   // load writes in the same stage that a sample reads, so order is kept
   aws_store u_store (
      .clock   (clock),
      .wr      (wr),
      .samp    (samp),
      .rd_data (rd_data)
   );

   // weights, per-channel products, rounding
   aws_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .samp      (samp),
      .rd_data   (rd_data),
      .push      (push),
      .push_data (push_data)
   );

   // result queue decouples the pipeline from the result channel
   aws_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .valid     (fifo_valid),
      .ready     (rsp_chan.ready),
      .head      (head)
   );

   assign rsp_chan.valid      = fifo_valid;
   assign rsp_chan.red_out    = head.red;
   assign rsp_chan.green_out  = head.green;
   assign rsp_chan.blue_out   = head.blue;
   assign rsp_chan.inside_res = head.hit;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (credit_ff != '0))
      else $error("result queued without outstanding credit");

   a_load_no_credit: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (kind_type'(req_chan.kind) == KIND_LOAD) && !rsp_pop)
      |=> $stable(credit_ff))
      else $error("load transaction changed credit count");

   a_push_with_credit: assert property (@(posedge clock) disable iff (reset)
      push |-> (credit_ff != '0))
      else $error("result produced with no sample in flight");
`endif

endmodule
